// File: rtl/elt_pkg.sv
// ---------------------------------------------------------------------------
// elt_pkg: shared types and constants of the extended low-power timer
// Item formats, op codes, counter widths and the fixed-point constants of
// the tick/microsecond conversions.
// ---------------------------------------------------------------------------
package elt_pkg;

  // Counter widths
  localparam int UPPER_BITS = 24;
  localparam int LOW_BITS   = 16;
  localparam int CNT_W      = UPPER_BITS + LOW_BITS;
  localparam int PCNT_W     = 7;
  localparam int SHIFT_W    = 3;
  localparam int LOG_W      = 4;
  localparam int US_IN_W    = 32;
  localparam int TIME_W     = 63;

  // Tick rate is 2^TICK_LOG Hz before the prescaler
  localparam logic [LOG_W-1:0]    TICK_LOG  = 4'd15;
  localparam logic [LOW_BITS-1:0] LOW_MASK  = 16'hffff;
  localparam logic [SHIFT_W-1:0]  SHIFT_RST = 3'd3;

  // Microseconds to ticks: x = (us << k) + half second, ticks = x / 1e6.
  // x / 1e6 = (x >> 6) / 15625, done by a reciprocal multiply that is exact
  // for the 30-bit quotient input.
  localparam int X_W         = 48;
  localparam int Y_W         = 30;
  localparam int PROD_W      = 61;
  localparam int RECIP_SHIFT = 44;
  localparam logic [X_W-1:0]    HALF_S_US = 48'd500000;
  localparam logic [X_W-1:0]    SAT_X     = 48'd65536000000;
  localparam logic [PROD_W-1:0] RECIP_M   = 61'd1125899907;

  // Ticks to microseconds: (count * 1e6) >> k, multiplied in two halves
  localparam int US_W    = 20;
  localparam int LO_W    = CNT_W / 2;
  localparam int HI_W    = CNT_W - LO_W;
  localparam int PP_LO_W = LO_W + US_W;
  localparam int PP_HI_W = HI_W + US_W;
  localparam int SUM_W   = (CNT_W + US_W > TIME_W) ? CNT_W + US_W : TIME_W;
  localparam logic [US_W-1:0] US_PER_S = 20'd1000000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_ALARM = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [US_IN_W-1:0] alarm_us;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_us;
    logic              alarm_fired;
    logic              overflowed;
  } out_item_t;

  // Converted alarm delay, conversion stage to state stage
  typedef struct packed {
    op_t                 op;
    logic [LOW_BITS-1:0] ticks;
  } conv_item_t;

  // State snapshot and tick flags, state stage to time stage
  typedef struct packed {
    op_t              op;
    logic [LOG_W-1:0] rate_log;
    logic             alarm_fired;
    logic             overflowed;
    logic [CNT_W-1:0] count;
  } core_item_t;

endpackage

// File: rtl/elt_conv.sv
// ---------------------------------------------------------------------------
// elt_conv: input register and alarm delay conversion
// Two stages: scale and round the microsecond delay, then divide by one
// million through a reciprocal multiply, saturating at 0xffff ticks.
// ---------------------------------------------------------------------------
module elt_conv
  import elt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SHIFT_W-1:0]   prescale_shift,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output conv_item_t           dn_data
);

  logic               s1_valid;
  op_t                s1_op;
  logic [US_IN_W-1:0] s1_us;
  logic               s2_valid;
  op_t                s2_op;
  logic               s2_sat;
  logic [Y_W-1:0]     s2_y;

  logic               s1_go;
  logic               s2_go;
  logic [LOG_W-1:0]   rate_log;
  logic [X_W-1:0]     x;
  logic [PROD_W-1:0]  prod;

  // Stage handshakes: a stage moves when the next one is empty or moving
  assign s2_go    = s2_valid && dn_ready;
  assign s1_go    = s1_valid && (!s2_valid || s2_go);
  assign in_ready = !s1_valid || s1_go;

  // Scale the delay by the tick rate and add half a second for rounding
  always_comb begin
    rate_log = TICK_LOG - {1'b0, prescale_shift};
    x        = (X_W'(s1_us) << rate_log) + HALF_S_US;
  end

  // Divide by one million, saturate
  always_comb begin
    prod          = PROD_W'(s2_y) * RECIP_M;
    dn_valid      = s2_valid;
    dn_data.op    = s2_op;
    dn_data.ticks = s2_sat ? LOW_MASK : prod[RECIP_SHIFT +: LOW_BITS];
  end

  // Hold stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_go) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op <= in_data.op;
      s1_us <= in_data.alarm_us;
    end
    if (s1_go) begin
      s2_op  <= s1_op;
      s2_sat <= (x >= SAT_X);
      s2_y   <= x[6 +: Y_W];
    end
  end

endmodule

// File: rtl/elt_core.sv
// ---------------------------------------------------------------------------
// elt_core: timer state stage
// Holds the prescaler, the 16-bit counter with its overflow extension, the
// one-shot alarm compare and the prescale register; applies one item a cycle while the next stage accepts it.
// ---------------------------------------------------------------------------
module elt_core
  import elt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [SHIFT_W-1:0]   cfg_data,
  output logic [SHIFT_W-1:0]   prescale_shift,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  conv_item_t           up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output core_item_t           dn_data
);

  logic                  s3_valid;
  op_t                   s3_op;
  logic [LOW_BITS-1:0]   s3_ticks;

  logic [PCNT_W-1:0]     prescale_count;
  logic [LOW_BITS-1:0]   low_count;
  logic [UPPER_BITS-1:0] upper_count;
  logic [LOW_BITS-1:0]   compare_value;
  logic                  alarm_armed;

  logic [PCNT_W-1:0]     prescale_count_next;
  logic [LOW_BITS-1:0]   low_count_next;
  logic [UPPER_BITS-1:0] upper_count_next;
  logic [LOW_BITS-1:0]   compare_value_next;
  logic                  alarm_armed_next;

  logic                  s3_go;
  logic [PCNT_W-1:0]     limit;
  logic [LOW_BITS-1:0]   alarm_val;

  assign s3_go    = s3_valid && dn_ready;
  assign up_ready = !s3_valid || s3_go;
  assign dn_valid = s3_valid;

  // Apply the item in the state stage to the timer state
  always_comb begin
    prescale_count_next = prescale_count;
    low_count_next      = low_count;
    upper_count_next    = upper_count;
    compare_value_next  = compare_value;
    alarm_armed_next    = alarm_armed;
    limit               = PCNT_W'((8'd1 << prescale_shift) - 8'd1);
    alarm_val           = low_count + s3_ticks;

    dn_data.op          = s3_op;
    dn_data.rate_log    = TICK_LOG - {1'b0, prescale_shift};
    dn_data.alarm_fired = 1'b0;
    dn_data.overflowed  = 1'b0;
    dn_data.count       = {upper_count, low_count};

    case (s3_op)
      OP_TICK: begin
        if (prescale_count >= limit) begin
          prescale_count_next = '0;
          low_count_next      = low_count + LOW_BITS'(1);
          if (low_count_next == '0) begin
            upper_count_next   = upper_count + UPPER_BITS'(1);
            dn_data.overflowed = 1'b1;
          end
          if (alarm_armed && (low_count_next == compare_value)) begin
            alarm_armed_next    = 1'b0;
            dn_data.alarm_fired = 1'b1;
          end
        end else begin
          prescale_count_next = prescale_count + PCNT_W'(1);
        end
      end
      OP_ALARM: begin
        // an all-ones compare value is replaced by zero before it is stored
        compare_value_next = (alarm_val == LOW_MASK) ? '0 : alarm_val;
        alarm_armed_next   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold state, advance on a transfer out of the state stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid       <= 1'b0;
      prescale_shift <= SHIFT_RST;
      prescale_count <= '0;
      low_count      <= '0;
      upper_count    <= '0;
      compare_value  <= '0;
      alarm_armed    <= 1'b0;
    end else begin
      if (up_ready) begin
        s3_valid <= up_valid;
      end
      if (cfg_we) begin
        prescale_shift <= cfg_data;
      end
      if (s3_go) begin
        prescale_count <= prescale_count_next;
        low_count      <= low_count_next;
        upper_count    <= upper_count_next;
        compare_value  <= compare_value_next;
        alarm_armed    <= alarm_armed_next;
      end
    end
  end

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      s3_op    <= up_data.op;
      s3_ticks <= up_data.ticks;
    end
  end

`ifndef SYNTHESIS
  a_alarm_arms: assert property (@(posedge clk) disable iff (rst)
    (s3_go && s3_op == OP_ALARM) |=> alarm_armed)
    else $error("alarm item did not arm the compare");

  a_fire_disarms: assert property (@(posedge clk) disable iff (rst)
    (s3_go && dn_data.alarm_fired) |=> !alarm_armed)
    else $error("alarm fired but stayed armed");

  a_fire_needs_arm: assert property (@(posedge clk) disable iff (rst)
    (s3_go && dn_data.alarm_fired) |-> alarm_armed)
    else $error("alarm fired while not armed");

  a_compare_legal: assert property (@(posedge clk) disable iff (rst)
    alarm_armed |-> (compare_value != LOW_MASK))
    else $error("armed compare value is all ones");

  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    (s3_go && dn_data.overflowed) |=> (low_count == '0))
    else $error("overflow flagged without counter wrap");
`endif

endmodule

// File: rtl/elt_time.sv
// ---------------------------------------------------------------------------
// elt_time: tick count to microseconds and result register
// Multiplies the combined count by one million in two halves, then sums,
// shifts by the tick rate and registers the result item.
// ---------------------------------------------------------------------------
module elt_time
  import elt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  core_item_t  up_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic               s4_valid;
  core_item_t         s4_data;
  logic               s5_valid;
  logic               s5_read;
  logic               s5_fired;
  logic               s5_ovf;
  logic [LOG_W-1:0]   s5_k;
  logic [PP_LO_W-1:0] s5_pp_lo;
  logic [PP_HI_W-1:0] s5_pp_hi;

  logic               s4_go;
  logic               s5_go;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   shifted;

  assign s5_go    = s5_valid && (!out_valid || out_ready);
  assign s4_go    = s4_valid && (!s5_valid || s5_go);
  assign up_ready = !s4_valid || s4_go;

  // Combine partial products and drop the fractional tick bits
  always_comb begin
    sum     = SUM_W'(s5_pp_lo) + (SUM_W'(s5_pp_hi) << LO_W);
    shifted = sum >> s5_k;
  end

  // Hold valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        s4_valid <= up_valid;
      end
      if (s4_go) begin
        s5_valid <= 1'b1;
      end else if (s5_go) begin
        s5_valid <= 1'b0;
      end
      if (s5_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Advance payloads
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      s4_data <= up_data;
    end
    if (s4_go) begin
      s5_read  <= (s4_data.op == OP_READ);
      s5_fired <= s4_data.alarm_fired;
      s5_ovf   <= s4_data.overflowed;
      s5_k     <= s4_data.rate_log;
      s5_pp_lo <= PP_LO_W'(s4_data.count[LO_W-1:0]) * PP_LO_W'(US_PER_S);
      s5_pp_hi <= PP_HI_W'(s4_data.count[CNT_W-1:LO_W]) * PP_HI_W'(US_PER_S);
    end
    if (s5_go) begin
      out_data.time_us     <= s5_read ? shifted[TIME_W-1:0] : '0;
      out_data.alarm_fired <= s5_fired;
      out_data.overflowed  <= s5_ovf;
    end
  end

endmodule

// File: rtl/extended_lowpower_timer_with_alarm_unit.sv
// ---------------------------------------------------------------------------
// extended_lowpower_timer_with_alarm_unit: low-power timer with alarm
// 16-bit prescaled tick counter with overflow extension, microsecond time
// read-out and a one-shot alarm compare.
// ---------------------------------------------------------------------------
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+--------------------------------
//   in       | in  | in_valid / in_ready   | in_data  (op, alarm_us)
//   out      | out | out_valid / out_ready | out_data (time_us, flags)
//   cfg      | in  | cfg_we                | cfg_data (prescale_shift)
//
// One item per cycle while the output is not stalled. The path is six
// register stages: input, reciprocal multiply, timer state, count hold,
// split count multiply, result register.
// Synchronous reset empties the pipeline, clears the counters, disarms the
// alarm and sets the prescale shift to 3.
// A stalled output fills the stages from the back; input stays ready while
// any stage is empty.
// ---------------------------------------------------------------------------
module extended_lowpower_timer_with_alarm_unit
  import elt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  logic [SHIFT_W-1:0] prescale_shift;
  logic               conv_valid;
  logic               conv_ready;
  conv_item_t         conv_data;
  logic               core_valid;
  logic               core_ready;
  core_item_t         core_data;

  // Convert alarm delays
  elt_conv u_conv (
    .clk            (clk),
    .rst            (rst),
    .prescale_shift (prescale_shift),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .dn_valid       (conv_valid),
    .dn_ready       (conv_ready),
    .dn_data        (conv_data)
  );

  // Apply items to the timer state
  elt_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .prescale_shift (prescale_shift),
    .up_valid       (conv_valid),
    .up_ready       (conv_ready),
    .up_data        (conv_data),
    .dn_valid       (core_valid),
    .dn_ready       (core_ready),
    .dn_data        (core_data)
  );

  // Convert counts to microseconds and register results
  elt_time u_time (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (core_valid),
    .up_ready  (core_ready),
    .up_data   (core_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: test/tb_extended_lowpower_timer_with_alarm_unit.sv
// ---------------------------------------------------------------------------
// tb_extended_lowpower_timer_with_alarm_unit: self-checking timer testbench
// Drives tick, read, set-alarm and unused-op transfers with random gaps and
// output stalls, predicts every result with an in-bench timer model and
// compares each output transfer field by field. Covers both prescale
// extremes and several settings between, and alarm saturation and mapping.
// ---------------------------------------------------------------------------
module tb_extended_lowpower_timer_with_alarm_unit;
  import elt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int IDLE_PCT     = 35;
  localparam int PIPE_DEPTH   = 5;
  localparam int RANDOM_ITEMS = 1525;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [1:0]  OP_CODE_UNUSED = 2'd3;
  localparam logic [63:0] TICK_RATE_HZ   = 64'd32768;
  localparam logic [63:0] MICROS_PER_SEC = 64'd1000000;
  localparam logic [63:0] HALF_SEC_US    = 64'd500000;
  localparam logic [63:0] TICK_SAT       = 64'hffff;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cfg_we    = 1'b0;
  logic [SHIFT_W-1:0] cfg_data = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Timer model state
  logic [SHIFT_W-1:0]    mdl_shift;
  logic [PCNT_W-1:0]     mdl_pcount;
  logic [LOW_BITS-1:0]   mdl_low;
  logic [UPPER_BITS-1:0] mdl_upper;
  logic [LOW_BITS-1:0]   mdl_compare;
  logic                  mdl_armed;

  out_item_t pending_results[$];
  int        errors       = 0;
  int        items_sent   = 0;
  int        results_seen = 0;
  int        alarms_seen  = 0;
  int        wraps_seen   = 0;
  int        cycle_count  = 0;
  logic      no_idle      = 1'b0;
  logic [7:0] shifts_seen = '0;

  extended_lowpower_timer_with_alarm_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stall the output side at random unless a no-idle stretch is running
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Combined tick count to microseconds at a rate of 2^(15-shift) Hz
  function automatic logic [TIME_W-1:0] count_to_us(logic [CNT_W-1:0] cnt,
                                                    logic [SHIFT_W-1:0] sh);
    int          k;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] us;
    k  = int'(TICK_LOG) - int'(sh);
    q  = 64'(cnt) >> k;
    r  = 64'(cnt) & ((64'd1 << k) - 64'd1);
    us = q * MICROS_PER_SEC + ((r * MICROS_PER_SEC) >> k);
    return us[TIME_W-1:0];
  endfunction

  // Rounded microsecond delay to ticks, saturating at 0xffff
  function automatic logic [LOW_BITS-1:0] delay_to_ticks(logic [US_IN_W-1:0] us,
                                                         logic [SHIFT_W-1:0] sh);
    logic [63:0] t;
    t = ((TICK_RATE_HZ >> sh) * 64'(us) + HALF_SEC_US) / MICROS_PER_SEC;
    if (t > TICK_SAT) t = TICK_SAT;
    return t[LOW_BITS-1:0];
  endfunction

  // Delay in microseconds that converts back to exactly d ticks
  function automatic logic [US_IN_W-1:0] us_for_ticks(logic [LOW_BITS-1:0] d,
                                                      logic [SHIFT_W-1:0] sh);
    logic [63:0] rate;
    rate = TICK_RATE_HZ >> sh;
    return US_IN_W'((64'(d) * MICROS_PER_SEC + rate / 2) / rate);
  endfunction

  // Advance the timer model by one item and return its result
  function automatic out_item_t advance_timer(in_item_t item);
    out_item_t           res;
    logic [LOW_BITS-1:0] target;
    res = '0;
    case (item.op)
      OP_TICK: begin
        if (int'(mdl_pcount) >= (1 << mdl_shift) - 1) begin
          mdl_pcount = '0;
          mdl_low    = mdl_low + LOW_BITS'(1);
          if (mdl_low == '0) begin
            mdl_upper      = mdl_upper + UPPER_BITS'(1);
            res.overflowed = 1'b1;
          end
          if (mdl_armed && mdl_low == mdl_compare) begin
            mdl_armed       = 1'b0;
            res.alarm_fired = 1'b1;
          end
        end else begin
          mdl_pcount = mdl_pcount + PCNT_W'(1);
        end
      end
      OP_READ: begin
        res.time_us = count_to_us({mdl_upper, mdl_low}, mdl_shift);
      end
      OP_ALARM: begin
        target = mdl_low + delay_to_ticks(item.alarm_us, mdl_shift);
        if (target == LOW_MASK) target = '0;
        mdl_compare = target;
        mdl_armed   = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t make_item(op_t op, logic [US_IN_W-1:0] us);
    in_item_t item;
    item.op       = op;
    item.alarm_us = us;
    return item;
  endfunction

  // Send one item; hold valid and payload until the transfer
  task automatic send_item(input in_item_t item);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(advance_timer(item));
    items_sent++;
  endtask

  // Hold off input until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_shift(input logic [SHIFT_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mdl_shift = value;
    shifts_seen[value] = 1'b1;
  endtask

  // Check each output transfer against the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_data.alarm_fired) alarms_seen++;
      if (out_data.overflowed) wraps_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.time_us !== want.time_us) begin
          $display("%0t: time_us mismatch, expected %0d, got %0d",
                   $time, want.time_us, out_data.time_us);
          errors++;
        end
        if (out_data.alarm_fired !== want.alarm_fired) begin
          $display("%0t: alarm_fired mismatch, expected %0b, got %0b",
                   $time, want.alarm_fired, out_data.alarm_fired);
          errors++;
        end
        if (out_data.overflowed !== want.overflowed) begin
          $display("%0t: overflowed mismatch, expected %0b, got %0b",
                   $time, want.overflowed, out_data.overflowed);
          errors++;
        end
      end
    end
  end

  // Field extremes, every op, alarm saturation and mapping, prescale drop
  task automatic test_directed_cases();
    // saturated delay from count 0 lands on 0xffff and is stored as 0
    send_item(make_item(OP_ALARM, 32'hffff_ffff));
    send_item(make_item(OP_READ, 32'h0));
    send_item(make_item(op_t'(OP_CODE_UNUSED), 32'hffff_ffff));
    // zero delay arms on the current count
    send_item(make_item(OP_ALARM, 32'h0));
    repeat (8) send_item(make_item(OP_TICK, $urandom()));
    send_item(make_item(OP_READ, $urandom()));
    // slowest prescale, then drop it below the prescaler count
    drain_results();
    write_shift(3'd7);
    repeat (6) send_item(make_item(OP_TICK, $urandom()));
    drain_results();
    write_shift(3'd1);
    send_item(make_item(OP_ALARM, us_for_ticks(16'd1, 3'd1)));
    send_item(make_item(OP_TICK, $urandom()));
    send_item(make_item(OP_READ, $urandom()));
    // fastest prescale with a short alarm
    drain_results();
    write_shift(3'd0);
    send_item(make_item(OP_ALARM, us_for_ticks(16'd2, 3'd0)));
    send_item(make_item(OP_TICK, $urandom()));
    send_item(make_item(OP_TICK, $urandom()));
    send_item(make_item(OP_READ, $urandom()));
    send_item(make_item(OP_ALARM, 32'hffff_ffff));
  endtask

  // Alarm-then-tick sequences with random content, mixed with noise
  task automatic test_random_traffic();
    int                 target;
    int                 phase_end;
    int                 phase;
    int                 d;
    int                 ticks;
    logic [SHIFT_W-1:0] sh;
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      // pick a prescale: both extremes first, then mostly fast settings
      if (phase == 0) sh = 3'd7;
      else if (phase == 1) sh = 3'd0;
      else if ($urandom_range(3) == 0) sh = SHIFT_W'($urandom_range(7));
      else sh = SHIFT_W'($urandom_range(4));
      drain_results();
      write_shift(sh);
      // one phase runs with no idling on either side
      no_idle   = (phase == 2);
      phase_end = items_sent + 150;
      while (items_sent < phase_end && items_sent < target) begin
        if ($urandom_range(99) < 70) begin
          d = (sh >= 3'd5) ? $urandom_range(2) : $urandom_range(16);
          if ($urandom_range(4) == 0) begin
            send_item(make_item(OP_ALARM, $urandom()));
          end else begin
            send_item(make_item(OP_ALARM, us_for_ticks(LOW_BITS'(d), sh)));
          end
          ticks = ((d + 1) << sh) + $urandom_range(3);
          for (int i = 0; i < ticks && items_sent < target; i++) begin
            if ($urandom_range(9) == 0) send_item(make_item(OP_READ, $urandom()));
            else send_item(make_item(OP_TICK, $urandom()));
          end
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_item(make_item(op_t'($urandom_range(3)), $urandom()));
          end
        end
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    mdl_shift   = SHIFT_RST;
    mdl_pcount  = '0;
    mdl_low     = '0;
    mdl_upper   = '0;
    mdl_compare = '0;
    mdl_armed   = 1'b0;
    shifts_seen[SHIFT_RST] = 1'b1;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic();

    drain_results();
    $display("Covered %0d transfers and %0d results over %0d prescale settings,",
             items_sent, results_seen, $countones(shifts_seen));
    $display("with %0d alarms fired and %0d counter wraps seen.", alarms_seen, wraps_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
